### sv/hrrn_pkg.sv
`default_nettype none
package hrrn_pkg;

  // queue geometry
  localparam int QUEUE_DEPTH = 16;
  localparam int QIDX_W      = $clog2(QUEUE_DEPTH);
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

  // field widths
  localparam int TIME_W = 32;
  localparam int MASK_W = 8;
  localparam int GCNT_W = 4;
  localparam int DUR_W  = 8;
  localparam int PROD_W = TIME_W + DUR_W;

  // function codes
  localparam logic FUNC_ENQ = 1'b0;

  // one waiting task as stored
  typedef struct packed {
    logic [TIME_W-1:0] submit;
    logic [MASK_W-1:0] mask;
    logic [GCNT_W-1:0] count;
    logic [DUR_W-1:0]  dur;
    logic              cmd;
  } entry_t;

  // memory write request
  typedef struct packed {
    logic              we;
    logic [QIDX_W-1:0] addr;
    entry_t            data;
  } mem_wr_t;

  // sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SRD,
    ST_SM1,
    ST_SM2,
    ST_CBEG,
    ST_CRD,
    ST_CWR,
    ST_DONE
  } state_t;

endpackage
`default_nettype wire

### sv/hrrn_qmem.sv
`default_nettype none
module hrrn_qmem (
  input  wire logic                       clk,
  input  wire hrrn_pkg::mem_wr_t          wr,
  input  wire logic [hrrn_pkg::QIDX_W-1:0] rd_addr,
  output hrrn_pkg::entry_t                rd_data
);

  hrrn_pkg::entry_t mem [hrrn_pkg::QUEUE_DEPTH];

  // one write port, registered read
  always_ff @(posedge clk) begin
    if (wr.we) begin
      mem[wr.addr] <= wr.data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule
`default_nettype wire

### sv/gpu_task_hrrn_scheduler_top.sv
// Waiting-task queue for one GPU machine, highest response ratio next.
// Input channel (in_valid / in_stall): one item per request. func 0 appends
// the task (or flags dropped when sixteen are waiting), then tries a start;
// func 1 only tries a start. in_stall is high while an item is in work.
// Result channel (out_valid / out_stall): exactly one item per input item,
// held stable in an output register while out_stall is high. The next input
// item is taken while a result still waits; a finished item waits in the
// last step only if the previous result has not yet been taken.
// Datapath: one shared 32x8 multiplier serves the ratio compare. Each queue
// entry is scanned with a memory read and two products; removal reads and
// writes back each entry behind the chosen one to move it down. Without a
// start no entry is moved; a try on an empty queue goes straight to the
// result step.
// Reset (rst_n low, synchronous) empties the queue and drops any result.
`default_nettype none
module gpu_task_hrrn_scheduler_top (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic       in_func,
  input  wire logic [31:0] in_now_seconds,
  input  wire logic [7:0] in_gpu_mask,
  input  wire logic [3:0] in_gpu_count,
  input  wire logic [7:0] in_duration_hours,
  input  wire logic       in_has_cmd,
  input  wire logic [7:0] in_available_gpu_mask,
  input  wire logic       in_night,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic            out_started,
  output logic [3:0]      out_slot,
  output logic [7:0]      out_start_gpu_mask,
  output logic [3:0]      out_start_gpu_count,
  output logic [7:0]      out_start_duration_hours,
  output logic            out_dropped,
  output logic [4:0]      out_waiting_count
);

  localparam int QW = hrrn_pkg::QIDX_W;
  localparam int CW = hrrn_pkg::CNT_W;
  localparam int PW = hrrn_pkg::PROD_W;

  hrrn_pkg::state_t state_r, state_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          out_valid_r, out_valid_nxt;

  logic [QW-1:0] idx_r;
  logic [QW-1:0] best_r;
  logic          found_r;
  logic [31:0]   bw_r;
  logic [7:0]    bd_r;
  logic [31:0]   w_r;
  logic [7:0]    d_r;
  logic          fit_r;
  logic [PW-1:0] prod_r;
  logic [7:0]    cand_mask_r, best_mask_r;
  logic [3:0]    cand_count_r, best_count_r;
  logic [7:0]    cand_dur_r, best_dur_r;
  logic          dropped_r;
  logic [31:0]   now_r;
  logic [7:0]    avail_r;
  logic [3:0]    popc_r;
  logic          night_r;

  hrrn_pkg::entry_t  rdata;
  hrrn_pkg::mem_wr_t wr;
  logic [QW-1:0]     rd_addr;

  logic          accept, enq_ok, done_load;
  logic [3:0]    popc_in;
  logic [31:0]   w_now;
  logic [7:0]    d_now;
  logic          fit_now;
  logic [31:0]   mul_a;
  logic [7:0]    mul_b;
  logic [PW-1:0] mul_p;
  logic          better;

  assign accept    = in_valid && !in_stall;
  assign enq_ok    = (in_func == hrrn_pkg::FUNC_ENQ) &&
                     (cnt_r < CW'(hrrn_pkg::QUEUE_DEPTH));
  assign done_load = (state_r == hrrn_pkg::ST_DONE) && (!out_valid_r || !out_stall);
  assign in_stall  = (state_r != hrrn_pkg::ST_IDLE);

  // free GPU count of the incoming mask
  always_comb begin
    popc_in = '0;
    for (int k = 0; k < 8; k++) begin
      popc_in = popc_in + {3'b0, in_available_gpu_mask[k]};
    end
  end

  // candidate entry evaluation
  assign w_now = now_r - rdata.submit;
  assign d_now = (rdata.dur == '0) ? 8'd1 : rdata.dur;
  always_comb begin
    if (night_r && !rdata.cmd) begin
      fit_now = 1'b0;
    end else if (rdata.count == '0) begin
      fit_now = ((rdata.mask & ~avail_r) == '0);
    end else begin
      fit_now = (popc_r >= rdata.count);
    end
  end

  // shared multiplier: w*bd first, then bw*d
  assign mul_a  = (state_r == hrrn_pkg::ST_SM1) ? w_now : bw_r;
  assign mul_b  = (state_r == hrrn_pkg::ST_SM1) ? bd_r  : d_r;
  assign mul_p  = PW'(mul_a) * PW'(mul_b);
  assign better = fit_r && (!found_r || (prod_r > mul_p));

  // memory ports
  assign rd_addr = (state_r == hrrn_pkg::ST_CRD) ? QW'(idx_r + 1'b1) : idx_r;
  always_comb begin
    wr = '0;
    if (accept && enq_ok) begin
      wr.we          = 1'b1;
      wr.addr        = cnt_r[QW-1:0];
      wr.data.submit = in_now_seconds;
      wr.data.mask   = in_gpu_mask;
      wr.data.count  = in_gpu_count;
      wr.data.dur    = in_duration_hours;
      wr.data.cmd    = in_has_cmd;
    end else if (state_r == hrrn_pkg::ST_CWR) begin
      wr.we   = 1'b1;
      wr.addr = idx_r;
      wr.data = rdata;
    end
  end

  hrrn_qmem u_qmem (
    .clk     (clk),
    .wr      (wr),
    .rd_addr (rd_addr),
    .rd_data (rdata)
  );

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r;
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
    case (state_r)
      hrrn_pkg::ST_IDLE: begin
        if (accept) begin
          if (enq_ok) begin
            cnt_nxt = cnt_r + 1'b1;
          end
          if (cnt_r == '0 && !enq_ok) begin
            state_nxt = hrrn_pkg::ST_DONE;
          end else begin
            state_nxt = hrrn_pkg::ST_SRD;
          end
        end
      end
      hrrn_pkg::ST_SRD: state_nxt = hrrn_pkg::ST_SM1;
      hrrn_pkg::ST_SM1: state_nxt = hrrn_pkg::ST_SM2;
      hrrn_pkg::ST_SM2: begin
        if (CW'(idx_r) + 1'b1 < cnt_r) begin
          state_nxt = hrrn_pkg::ST_SRD;
        end else begin
          state_nxt = hrrn_pkg::ST_CBEG;
        end
      end
      hrrn_pkg::ST_CBEG: begin
        if (found_r && (CW'(best_r) + 1'b1 < cnt_r)) begin
          state_nxt = hrrn_pkg::ST_CRD;
        end else begin
          state_nxt = hrrn_pkg::ST_DONE;
        end
      end
      hrrn_pkg::ST_CRD: state_nxt = hrrn_pkg::ST_CWR;
      hrrn_pkg::ST_CWR: begin
        if (CW'(idx_r) + 2'd2 < cnt_r) begin
          state_nxt = hrrn_pkg::ST_CRD;
        end else begin
          state_nxt = hrrn_pkg::ST_DONE;
        end
      end
      hrrn_pkg::ST_DONE: begin
        if (done_load) begin
          out_valid_nxt = 1'b1;
          cnt_nxt       = cnt_r - CW'(found_r);
          state_nxt     = hrrn_pkg::ST_IDLE;
        end
      end
      default: state_nxt = hrrn_pkg::ST_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= hrrn_pkg::ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (state_r)
      hrrn_pkg::ST_IDLE: begin
        if (accept) begin
          now_r     <= in_now_seconds;
          avail_r   <= in_available_gpu_mask;
          popc_r    <= popc_in;
          night_r   <= in_night;
          dropped_r <= (in_func == hrrn_pkg::FUNC_ENQ) && !enq_ok;
          idx_r     <= '0;
          found_r   <= 1'b0;
          best_r    <= '0;
          bw_r      <= '0;
          bd_r      <= 8'd1;
        end
      end
      hrrn_pkg::ST_SM1: begin
        w_r          <= w_now;
        d_r          <= d_now;
        fit_r        <= fit_now;
        prod_r       <= mul_p;
        cand_mask_r  <= rdata.mask;
        cand_count_r <= rdata.count;
        cand_dur_r   <= rdata.dur;
      end
      hrrn_pkg::ST_SM2: begin
        if (better) begin
          found_r      <= 1'b1;
          best_r       <= idx_r;
          bw_r         <= w_r;
          bd_r         <= d_r;
          best_mask_r  <= cand_mask_r;
          best_count_r <= cand_count_r;
          best_dur_r   <= cand_dur_r;
        end
        idx_r <= idx_r + 1'b1;
      end
      hrrn_pkg::ST_CBEG: idx_r <= best_r;
      hrrn_pkg::ST_CWR:  idx_r <= idx_r + 1'b1;
      default: begin
      end
    endcase
  end

  // result register
  always_ff @(posedge clk) begin
    if (done_load) begin
      out_started              <= found_r;
      out_slot                 <= found_r ? best_r : '0;
      out_start_gpu_mask       <= found_r ? best_mask_r : '0;
      out_start_gpu_count      <= found_r ? best_count_r : '0;
      out_start_duration_hours <= found_r ? best_dur_r : '0;
      out_dropped              <= dropped_r;
      out_waiting_count        <= cnt_r - CW'(found_r);
    end
  end

  assign out_valid = out_valid_r;

endmodule
`default_nettype wire

### dv/gpu_task_hrrn_checker.sv
`default_nettype none
// Watches both channels of the HRRN task queue, keeps its own copy of the
// waiting tasks and checks every result item against the predicted start.
module gpu_task_hrrn_checker (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  input  wire logic                        in_stall,
  input  wire logic                        in_func,
  input  wire logic [hrrn_pkg::TIME_W-1:0] in_now_seconds,
  input  wire logic [hrrn_pkg::MASK_W-1:0] in_gpu_mask,
  input  wire logic [hrrn_pkg::GCNT_W-1:0] in_gpu_count,
  input  wire logic [hrrn_pkg::DUR_W-1:0]  in_duration_hours,
  input  wire logic                        in_has_cmd,
  input  wire logic [hrrn_pkg::MASK_W-1:0] in_available_gpu_mask,
  input  wire logic                        in_night,
  input  wire logic                        out_valid,
  input  wire logic                        out_stall,
  input  wire logic                        out_started,
  input  wire logic [hrrn_pkg::QIDX_W-1:0] out_slot,
  input  wire logic [hrrn_pkg::MASK_W-1:0] out_start_gpu_mask,
  input  wire logic [hrrn_pkg::GCNT_W-1:0] out_start_gpu_count,
  input  wire logic [hrrn_pkg::DUR_W-1:0]  out_start_duration_hours,
  input  wire logic                        out_dropped,
  input  wire logic [hrrn_pkg::CNT_W-1:0]  out_waiting_count,
  output int                               n_fail,
  output int                               n_pending
);
  timeunit 1ns;
  timeprecision 1ps;

  // one predicted start report
  typedef struct packed {
    logic                        started;
    logic [hrrn_pkg::QIDX_W-1:0] slot;
    logic [hrrn_pkg::MASK_W-1:0] mask;
    logic [hrrn_pkg::GCNT_W-1:0] count;
    logic [hrrn_pkg::DUR_W-1:0]  dur;
    logic                        dropped;
    logic [hrrn_pkg::CNT_W-1:0]  waiting;
  } start_rpt_t;

  hrrn_pkg::entry_t wait_q [hrrn_pkg::QUEUE_DEPTH];
  int               wait_cnt = 0;
  start_rpt_t       expected_starts [$];
  int               fails = 0;
  int               pend = 0;

  assign n_fail    = fails;
  assign n_pending = pend;

  // night skips tasks without a command; specific mode needs every named GPU
  function automatic logic task_fits(hrrn_pkg::entry_t e,
                                     logic [hrrn_pkg::MASK_W-1:0] avail,
                                     logic night);
    if (night && !e.cmd) return 1'b0;
    if (e.count == '0) return (e.mask & ~avail) == '0;
    return $countones(avail) >= e.count;
  endfunction

  // append (if asked), pick the best ratio among fitting tasks, compact
  task automatic schedule_step(input logic func,
                               input logic [hrrn_pkg::TIME_W-1:0] now,
                               input logic [hrrn_pkg::MASK_W-1:0] mask,
                               input logic [hrrn_pkg::GCNT_W-1:0] cnt,
                               input logic [hrrn_pkg::DUR_W-1:0] dur,
                               input logic cmd,
                               input logic [hrrn_pkg::MASK_W-1:0] avail,
                               input logic night);
    start_rpt_t       rpt;
    hrrn_pkg::entry_t pick;
    logic             found;
    int               best;
    int               i;
    logic [63:0]      w, d, bw, bd;
    rpt   = '0;
    pick  = '0;
    found = 1'b0;
    best  = 0;
    bw    = '0;
    bd    = 64'd1;
    if (func == hrrn_pkg::FUNC_ENQ) begin
      if (wait_cnt >= hrrn_pkg::QUEUE_DEPTH) begin
        rpt.dropped = 1'b1;
      end else begin
        wait_q[wait_cnt].submit = now;
        wait_q[wait_cnt].mask   = mask;
        wait_q[wait_cnt].count  = cnt;
        wait_q[wait_cnt].dur    = dur;
        wait_q[wait_cnt].cmd    = cmd;
        wait_cnt++;
      end
    end
    // wait wraps modulo 2^32; zero duration counts as one hour
    for (i = 0; i < wait_cnt; i++) begin
      if (task_fits(wait_q[i], avail, night)) begin
        w = {32'd0, now - wait_q[i].submit};
        d = (wait_q[i].dur == '0) ? 64'd1 : {56'd0, wait_q[i].dur};
        if (!found || w * bd > bw * d) begin
          found = 1'b1;
          best  = i;
          bw    = w;
          bd    = d;
        end
      end
    end
    if (found) begin
      pick = wait_q[best];
      for (i = best; i < wait_cnt - 1; i++) wait_q[i] = wait_q[i + 1];
      wait_cnt--;
      rpt.started = 1'b1;
      rpt.slot    = hrrn_pkg::QIDX_W'(best);
      rpt.mask    = pick.mask;
      rpt.count   = pick.count;
      rpt.dur     = pick.dur;
    end
    rpt.waiting = hrrn_pkg::CNT_W'(wait_cnt);
    expected_starts.push_back(rpt);
  endtask

  // results are checked before the same edge's input is predicted
  always @(posedge clk) begin
    start_rpt_t exp_r;
    start_rpt_t got;
    if (!rst_n) begin
      wait_cnt = 0;
      expected_starts.delete();
    end else begin
      if (out_valid && !out_stall) begin
        got = '{out_started, out_slot, out_start_gpu_mask, out_start_gpu_count,
                out_start_duration_hours, out_dropped, out_waiting_count};
        if (expected_starts.size() == 0) begin
          fails++;
          if (fails <= 10)
            $display("[%0t] result item with nothing expected: started=%0b slot=%0d",
                     $realtime, got.started, got.slot);
        end else begin
          exp_r = expected_starts.pop_front();
          if (got.started !== exp_r.started || got.slot !== exp_r.slot ||
              got.mask !== exp_r.mask || got.count !== exp_r.count ||
              got.dur !== exp_r.dur || got.dropped !== exp_r.dropped ||
              got.waiting !== exp_r.waiting) begin
            fails++;
            if (fails <= 10) begin
              $display(
                "[%0t] exp: st=%0b slot=%0d mask=%02h cnt=%0d dur=%0d drop=%0b wt=%0d",
                $realtime, exp_r.started, exp_r.slot, exp_r.mask, exp_r.count,
                exp_r.dur, exp_r.dropped, exp_r.waiting);
              $display(
                "[%0t] got: st=%0b slot=%0d mask=%02h cnt=%0d dur=%0d drop=%0b wt=%0d",
                $realtime, got.started, got.slot, got.mask, got.count,
                got.dur, got.dropped, got.waiting);
            end
          end
        end
      end
      if (in_valid && !in_stall)
        schedule_step(in_func, in_now_seconds, in_gpu_mask, in_gpu_count,
                      in_duration_hours, in_has_cmd, in_available_gpu_mask, in_night);
    end
    pend = expected_starts.size();
  end

endmodule
`default_nettype wire

### dv/tb_gpu_task_hrrn_scheduler_top.sv
`default_nettype none
module tb_gpu_task_hrrn_scheduler_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic FUNC_TRY  = ~hrrn_pkg::FUNC_ENQ;
  localparam int   HOLD_LEN  = 400;
  localparam int   PHASE_LEN = 212;

  // one request as offered to the block
  typedef struct packed {
    logic                        func;
    logic [hrrn_pkg::TIME_W-1:0] now;
    logic [hrrn_pkg::MASK_W-1:0] gpu_mask;
    logic [hrrn_pkg::GCNT_W-1:0] gpu_count;
    logic [hrrn_pkg::DUR_W-1:0]  dur;
    logic                        has_cmd;
    logic [hrrn_pkg::MASK_W-1:0] avail;
    logic                        night;
  } sched_req_t;

  logic                        clk = 1'b0;
  logic                        rst_n = 1'b0;
  logic                        in_valid = 1'b0;
  logic                        in_stall;
  logic                        in_func = hrrn_pkg::FUNC_ENQ;
  logic [hrrn_pkg::TIME_W-1:0] in_now_seconds = '0;
  logic [hrrn_pkg::MASK_W-1:0] in_gpu_mask = '0;
  logic [hrrn_pkg::GCNT_W-1:0] in_gpu_count = '0;
  logic [hrrn_pkg::DUR_W-1:0]  in_duration_hours = 8'd1;
  logic                        in_has_cmd = 1'b0;
  logic [hrrn_pkg::MASK_W-1:0] in_available_gpu_mask = '0;
  logic                        in_night = 1'b0;
  logic                        out_valid;
  logic                        out_stall = 1'b0;
  logic                        out_started;
  logic [hrrn_pkg::QIDX_W-1:0] out_slot;
  logic [hrrn_pkg::MASK_W-1:0] out_start_gpu_mask;
  logic [hrrn_pkg::GCNT_W-1:0] out_start_gpu_count;
  logic [hrrn_pkg::DUR_W-1:0]  out_start_duration_hours;
  logic                        out_dropped;
  logic [hrrn_pkg::CNT_W-1:0]  out_waiting_count;
  int                          n_fail;
  int                          n_pending;

  int unsigned                 tx_idle_pct = 0;
  int unsigned                 rx_stall_pct = 0;
  logic                        hold_req = 1'b0;
  int                          hold_left = 0;
  logic [hrrn_pkg::TIME_W-1:0] clock_s = 32'd1000;
  int                          stuck_budget = 2;
  int unsigned                 tx_pct_of [4] = '{0, 84, 0, 23};
  int unsigned                 rx_pct_of [4] = '{0, 0, 84, 23};

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  gpu_task_hrrn_scheduler_top u_dut (
    .clk                      (clk),
    .rst_n                    (rst_n),
    .in_valid                 (in_valid),
    .in_stall                 (in_stall),
    .in_func                  (in_func),
    .in_now_seconds           (in_now_seconds),
    .in_gpu_mask              (in_gpu_mask),
    .in_gpu_count             (in_gpu_count),
    .in_duration_hours        (in_duration_hours),
    .in_has_cmd               (in_has_cmd),
    .in_available_gpu_mask    (in_available_gpu_mask),
    .in_night                 (in_night),
    .out_valid                (out_valid),
    .out_stall                (out_stall),
    .out_started              (out_started),
    .out_slot                 (out_slot),
    .out_start_gpu_mask       (out_start_gpu_mask),
    .out_start_gpu_count      (out_start_gpu_count),
    .out_start_duration_hours (out_start_duration_hours),
    .out_dropped              (out_dropped),
    .out_waiting_count        (out_waiting_count)
  );

  gpu_task_hrrn_checker u_check (
    .clk                      (clk),
    .rst_n                    (rst_n),
    .in_valid                 (in_valid),
    .in_stall                 (in_stall),
    .in_func                  (in_func),
    .in_now_seconds           (in_now_seconds),
    .in_gpu_mask              (in_gpu_mask),
    .in_gpu_count             (in_gpu_count),
    .in_duration_hours        (in_duration_hours),
    .in_has_cmd               (in_has_cmd),
    .in_available_gpu_mask    (in_available_gpu_mask),
    .in_night                 (in_night),
    .out_valid                (out_valid),
    .out_stall                (out_stall),
    .out_started              (out_started),
    .out_slot                 (out_slot),
    .out_start_gpu_mask       (out_start_gpu_mask),
    .out_start_gpu_count      (out_start_gpu_count),
    .out_start_duration_hours (out_start_duration_hours),
    .out_dropped              (out_dropped),
    .out_waiting_count        (out_waiting_count),
    .n_fail                   (n_fail),
    .n_pending                (n_pending)
  );

  // receiver: random stalls, or one long hold-off once requested
  always @(posedge clk) begin
    if (hold_req) begin
      hold_left = HOLD_LEN;
      hold_req  = 1'b0;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < rx_stall_pct);
    end
  end

  function automatic sched_req_t req(logic func, logic [hrrn_pkg::TIME_W-1:0] now,
                                     logic [hrrn_pkg::MASK_W-1:0] mask,
                                     logic [hrrn_pkg::GCNT_W-1:0] cnt,
                                     logic [hrrn_pkg::DUR_W-1:0] dur, logic cmd,
                                     logic [hrrn_pkg::MASK_W-1:0] avail, logic night);
    return '{func, now, mask, cnt, dur, cmd, avail, night};
  endfunction

  // random request on a mostly rising clock, with the odd jump anywhere
  function automatic sched_req_t random_req();
    sched_req_t  r;
    int unsigned pick;
    r.func = ($urandom_range(99) < 55) ? hrrn_pkg::FUNC_ENQ : FUNC_TRY;
    if ($urandom_range(99) < 3) clock_s = $urandom();
    else clock_s += $urandom_range(0, 5000);
    r.now      = clock_s;
    r.gpu_mask = ($urandom_range(9) == 0) ? 8'h00 : hrrn_pkg::MASK_W'($urandom());
    // counts beyond the machine never start, so only a couple are let in
    pick = $urandom_range(199);
    if (pick < 100) begin
      r.gpu_count = '0;
    end else if (pick == 199 && stuck_budget != 0 && r.func == hrrn_pkg::FUNC_ENQ) begin
      r.gpu_count = hrrn_pkg::GCNT_W'($urandom_range(9, 15));
      stuck_budget--;
    end else begin
      r.gpu_count = hrrn_pkg::GCNT_W'($urandom_range(1, 8));
    end
    pick = $urandom_range(99);
    if (pick < 5) r.dur = '0;
    else if (pick < 40) r.dur = hrrn_pkg::DUR_W'($urandom_range(1, 4));
    else r.dur = hrrn_pkg::DUR_W'($urandom_range(1, 255));
    r.has_cmd = ($urandom_range(99) < 70);
    pick = $urandom_range(99);
    if (pick < 20) r.avail = '0;
    else if (pick < 35) r.avail = 8'hFF;
    else r.avail = hrrn_pkg::MASK_W'($urandom());
    r.night = ($urandom_range(99) < 25);
    return r;
  endfunction

  // offer one item, with random idle cycles first, and wait for acceptance
  task automatic send_item(input sched_req_t r);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid              <= 1'b1;
    in_func               <= r.func;
    in_now_seconds        <= r.now;
    in_gpu_mask           <= r.gpu_mask;
    in_gpu_count          <= r.gpu_count;
    in_duration_hours     <= r.dur;
    in_has_cmd            <= r.has_cmd;
    in_available_gpu_mask <= r.avail;
    in_night              <= r.night;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  initial begin
    sched_req_t r;
    int         k;
    int         n;
    int         ph;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: empty queue, empty mask, fill to overflow, wrapped clock
    send_item(req(FUNC_TRY, 32'd0, 8'h00, 4'd0, 8'd1, 1'b0, 8'hFF, 1'b0));
    send_item(req(hrrn_pkg::FUNC_ENQ, 32'hFFFF_FFFF, 8'h00, 4'd0, 8'd1, 1'b0, 8'h00,
                  1'b0));
    for (k = 0; k < 17; k++) begin
      send_item(req(hrrn_pkg::FUNC_ENQ, 32'hFFFF_F000 + 32'(k * 600),
                    hrrn_pkg::MASK_W'(k * 37 + 1),
                    (k == 5) ? 4'd15 : hrrn_pkg::GCNT_W'(k % 8 + 1),
                    (k == 3) ? 8'd0 : (k == 4) ? 8'd255 : hrrn_pkg::DUR_W'(k % 5 + 1),
                    k[0], 8'h00, k[1]));
    end
    // night start only among tasks with a command
    send_item(req(FUNC_TRY, 32'h0000_5000, 8'h00, 4'd0, 8'd1, 1'b0, 8'hFF, 1'b1));
    send_item(req(FUNC_TRY, 32'h0000_1000, 8'h00, 4'd0, 8'd1, 1'b0, 8'h0F, 1'b0));
    send_item(req(FUNC_TRY, 32'd0, 8'h00, 4'd0, 8'd1, 1'b0, 8'hFF, 1'b0));
    send_item(req(hrrn_pkg::FUNC_ENQ, 32'hFFFF_FFFF, 8'hFF, 4'd0, 8'd255, 1'b1, 8'hFF,
                  1'b1));
    send_item(req(FUNC_TRY, 32'h0001_0000, 8'h00, 4'd0, 8'd1, 1'b0, 8'hFF, 1'b0));
    send_item(req(FUNC_TRY, 32'h0002_0000, 8'h00, 4'd0, 8'd1, 1'b0, 8'h01, 1'b0));

    // random phases with different idling on both sides
    for (ph = 0; ph < 4; ph++) begin
      tx_idle_pct  = tx_pct_of[ph];
      rx_stall_pct = rx_pct_of[ph];
      n = 0;
      while (n < PHASE_LEN) begin
        if (ph == 0 && n == 100) hold_req = 1'b1;
        if (n % 106 == 50) begin
          // burst of appends with no free GPUs to reach a full queue and drops
          for (k = 0; k < 18; k++) begin
            r       = random_req();
            r.func  = hrrn_pkg::FUNC_ENQ;
            r.avail = '0;
            send_item(r);
          end
          n += 18;
        end else begin
          send_item(random_req());
          n++;
        end
      end
    end
    in_valid <= 1'b0;
    rx_stall_pct = 0;

    // drain, then allow the longest item time to pass
    @(posedge clk);
    while (n_pending != 0) @(posedge clk);
    repeat (120) @(posedge clk);
    if (n_fail == 0 && n_pending == 0) begin
      $display("gpu_task_hrrn_scheduler_top regression: pass");
    end else begin
      $display("gpu_task_hrrn_scheduler_top regression: fail");
    end
    $finish;
  end

  // run limit
  initial begin
    #10_000_000;
    $display("gpu_task_hrrn_scheduler_top regression: fail");
    $finish;
  end

endmodule
`default_nettype wire

### files.f
sv/hrrn_pkg.sv
sv/hrrn_qmem.sv
sv/gpu_task_hrrn_scheduler_top.sv
dv/gpu_task_hrrn_checker.sv
dv/tb_gpu_task_hrrn_scheduler_top.sv
